### design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/ibfd_pkg.sv
`default_nettype none
package ibfd_pkg;

    // Frame geometry
    localparam int UserCh      = 6;
    localparam int FrameCh     = 14;
    localparam int ByteW       = 8;
    localparam int ChIdxW      = 4;
    localparam int ChValW      = 16;
    localparam int PosW        = 5;
    localparam int StoreAw     = (UserCh > 1) ? $clog2(UserCh) : 1;
    localparam int LastDataPos = 2 + 2 * FrameCh - 1;
    localparam int CsumLoPos   = 30;
    localparam int CsumHiPos   = 31;

    localparam logic [ChValW-1:0] CsumStart   = 16'hFFFF;
    localparam logic [ByteW-1:0]  HdrFirstRst = 8'd32;
    localparam logic [ByteW-1:0]  HdrSecondRst = 8'd64;

    // Configuration register indexes
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 1'b1;

    // Result queue between front and back
    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;

    typedef struct packed {
        logic [ChIdxW-1:0] index;
        logic [ChValW-1:0] value;
        logic              last;
    } t_result;

    // Queue handshake seen from the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

### design/ibfd_front.sv
`default_nettype none
module ibfd_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // byte input
    input  wire                                i_push,
    output logic                               o_full,
    input  wire  [ibfd_pkg::ByteW-1:0]         i_rx_byte,
    // configuration
    input  wire                                i_cfg_valid,
    input  wire  [ibfd_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  wire  [ibfd_pkg::ByteW-1:0]         i_cfg_data,
    // result queue write side
    input  wire  ibfd_pkg::t_qstat             i_qstat,
    output logic                               o_q_push,
    output ibfd_pkg::t_result                  o_q_data
);

    typedef enum logic [3:0] {
        ST_HUNT   = 4'b0001,
        ST_SECOND = 4'b0010,
        ST_BODY   = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

    t_state                              r_state, n_state;
    logic [ibfd_pkg::PosW-1:0]           r_pos, n_pos;
    logic [ibfd_pkg::ChValW-1:0]         r_csum, n_csum;
    logic [ibfd_pkg::ByteW-1:0]          r_low, n_low;
    logic [ibfd_pkg::ChIdxW-1:0]         r_emit, n_emit;
    logic [ibfd_pkg::ByteW-1:0]          r_hdr1, r_hdr2;
    logic [ibfd_pkg::ChValW-1:0]         r_store [ibfd_pkg::UserCh];

    logic                                accept;
    logic                                store_we;
    logic [ibfd_pkg::ChIdxW-1:0]         ch_num;
    logic [ibfd_pkg::ChValW-1:0]         got_csum;
    logic                                emit_last;

    assign o_full   = (r_state == ST_EMIT);
    assign accept   = i_push && !o_full;
    // channel number of the word whose high byte is at r_pos
    assign ch_num   = r_pos[ibfd_pkg::PosW-1:1] - ibfd_pkg::ChIdxW'(1);
    assign got_csum = {i_rx_byte, r_low};
    assign emit_last = (r_emit == ibfd_pkg::ChIdxW'(ibfd_pkg::UserCh - 1));

    // result request toward the queue
    assign o_q_push       = (r_state == ST_EMIT) && !i_qstat.full;
    assign o_q_data.index = r_emit;
    assign o_q_data.value = r_store[r_emit[ibfd_pkg::StoreAw-1:0]];
    assign o_q_data.last  = emit_last;

    // frame parser
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_csum   = r_csum;
        n_low    = r_low;
        n_emit   = r_emit;
        store_we = 1'b0;
        unique case (r_state)
            ST_HUNT, ST_SECOND: begin
                if (accept) begin
                    if (r_state == ST_SECOND && i_rx_byte == r_hdr2) begin
                        n_csum  = r_csum - ibfd_pkg::ChValW'(i_rx_byte);
                        n_state = ST_BODY;
                        n_pos   = ibfd_pkg::PosW'(2);
                    end else if (i_rx_byte == r_hdr1) begin
                        n_csum  = ibfd_pkg::CsumStart - ibfd_pkg::ChValW'(i_rx_byte);
                        n_state = ST_SECOND;
                        n_pos   = ibfd_pkg::PosW'(1);
                    end else begin
                        n_csum  = ibfd_pkg::CsumStart;
                        n_state = ST_HUNT;
                        n_pos   = '0;
                    end
                end
            end
            ST_BODY: begin
                if (accept) begin
                    if (r_pos <= ibfd_pkg::PosW'(ibfd_pkg::LastDataPos)) begin
                        n_csum = r_csum - ibfd_pkg::ChValW'(i_rx_byte);
                        if (!r_pos[0]) begin
                            n_low = i_rx_byte;
                        end else if (ch_num < ibfd_pkg::ChIdxW'(ibfd_pkg::UserCh)) begin
                            store_we = 1'b1;
                        end
                        n_pos = r_pos + ibfd_pkg::PosW'(1);
                    end else if (r_pos == ibfd_pkg::PosW'(ibfd_pkg::CsumLoPos)) begin
                        n_low = i_rx_byte;
                        n_pos = ibfd_pkg::PosW'(ibfd_pkg::CsumHiPos);
                    end else begin
                        // checksum high byte closes the frame
                        n_csum  = ibfd_pkg::CsumStart;
                        n_pos   = '0;
                        n_emit  = '0;
                        n_state = (got_csum == r_csum) ? ST_EMIT : ST_HUNT;
                    end
                end
            end
            ST_EMIT: begin
                if (o_q_push) begin
                    n_emit = r_emit + ibfd_pkg::ChIdxW'(1);
                    if (emit_last) begin
                        n_state = ST_HUNT;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
                n_pos   = '0;
                n_csum  = ibfd_pkg::CsumStart;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_pos   <= '0;
            r_csum  <= ibfd_pkg::CsumStart;
            r_low   <= '0;
            r_emit  <= '0;
            r_hdr1  <= ibfd_pkg::HdrFirstRst;
            r_hdr2  <= ibfd_pkg::HdrSecondRst;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_csum  <= n_csum;
            r_low   <= n_low;
            r_emit  <= n_emit;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ibfd_pkg::CFG_HEADER_FIRST:  r_hdr1 <= i_cfg_data;
                    ibfd_pkg::CFG_HEADER_SECOND: r_hdr2 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // channel store, one word per user channel
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[ch_num[ibfd_pkg::StoreAw-1:0]] <= {i_rx_byte, r_low};
        end
    end

endmodule
`default_nettype wire

### design/ibfd_queue.sv
`default_nettype none
module ibfd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  ibfd_pkg::t_result   i_data,
    input  wire                 i_pop,
    output ibfd_pkg::t_result   o_data,
    output ibfd_pkg::t_qstat    o_stat
);

    ibfd_pkg::t_result              r_mem [ibfd_pkg::QueueDepth];
    logic [ibfd_pkg::QueueAw-1:0]   r_wptr, r_rptr;
    logic [ibfd_pkg::QueueAw:0]     r_count;
    logic                           do_push, do_pop;

    assign o_stat.full  = (r_count == (ibfd_pkg::QueueAw + 1)'(ibfd_pkg::QueueDepth));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + ibfd_pkg::QueueAw'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + ibfd_pkg::QueueAw'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (ibfd_pkg::QueueAw + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (ibfd_pkg::QueueAw + 1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

### design/ibfd_back.sv
`default_nettype none
module ibfd_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // queue read side
    input  ibfd_pkg::t_qstat                 i_qstat,
    input  ibfd_pkg::t_result                i_q_data,
    output logic                             o_q_pop,
    // result port
    output logic                             o_empty,
    input  wire                              i_pop,
    output logic [ibfd_pkg::ChIdxW-1:0]      o_channel_index,
    output logic [ibfd_pkg::ChValW-1:0]      o_channel_value,
    output logic                             o_last_channel
);

    logic              r_valid;
    ibfd_pkg::t_result r_out;

    // refill the output register when it is free or being taken
    assign o_q_pop         = !i_qstat.empty && (!r_valid || i_pop);
    assign o_empty         = !r_valid;
    assign o_channel_index = r_out.index;
    assign o_channel_value = r_out.value;
    assign o_last_channel  = r_out.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= i_q_data;
        end
    end

endmodule
`default_nettype wire

### design/ibus_frame_decoder.sv
// The frame parser takes each received byte while full is low; full stays low while it parses.
// A final byte with a good checksum starts a transfer of UserCh results out of the channel
// store, one per cycle while the queue has room; full stays high until the last is queued.
// Results reach the port through the queue and output register, one per cycle while pop is high.
// Reset is synchronous, active low: hunting, empty queue, headers 0x20 and 0x40.
`default_nettype none
module ibus_frame_decoder (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // byte input
    input  wire                              push,
    output logic                             full,
    input  wire  [ibfd_pkg::ByteW-1:0]       i_rx_byte,
    // results
    output logic                             empty,
    input  wire                              pop,
    output logic [ibfd_pkg::ChIdxW-1:0]     o_channel_index,
    output logic [ibfd_pkg::ChValW-1:0]     o_channel_value,
    output logic                             o_last_channel,
    // configuration
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [ibfd_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire  [ibfd_pkg::ByteW-1:0]       i_cfg_data
);

    ibfd_pkg::t_qstat  qstat;
    ibfd_pkg::t_result q_wdata, q_rdata;
    logic              q_push, q_pop;

    assign o_cfg_ready = 1'b1;

    ibfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    ibfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_stat  (qstat)
    );

    ibfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qstat         (qstat),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

endmodule
`default_nettype wire

### design/ibfd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ibfd_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             empty,
    input wire                             pop,
    input wire [ibfd_pkg::ChIdxW-1:0]      o_channel_index,
    input wire [ibfd_pkg::ChValW-1:0]      o_channel_value,
    input wire                             o_last_channel
);

    // last flag only on the final user channel
    `ASSERT_NOW(a_last_index, i_clk, !i_rst_n, !empty && o_last_channel, o_channel_index == ibfd_pkg::ChIdxW'(ibfd_pkg::UserCh - 1))

    // results of one frame come in index order without gaps
    `ASSERT_NEXT(a_index_step, i_clk, !i_rst_n, !empty && pop && !o_last_channel, !empty && o_channel_index == $past(o_channel_index) + ibfd_pkg::ChIdxW'(1))

    // a waiting result holds until taken
    `ASSERT_NEXT(a_hold, i_clk, !i_rst_n, !empty && !pop, !empty && $stable(o_channel_value) && $stable(o_channel_index))

    // reset leaves nothing to pop
    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, empty)

endmodule

bind ibus_frame_decoder ibfd_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_channel_index (o_channel_index),
    .o_channel_value (o_channel_value),
    .o_last_channel  (o_last_channel)
);
`default_nettype wire
